/* rtl/deq_pkg.sv */
// ----------------------------------------------------------------------------
// deq_pkg
// Shared types and codes for the double-ended queue: command codes, decoded
// operations, status codes and the word that travels from the front part to
// the back part.
// ----------------------------------------------------------------------------
package deq_pkg;

    localparam int DATA_W        = 32;
    localparam int DEPTH_DEFAULT = 16;
    localparam int CMD_W         = 3;
    localparam int STATUS_W      = 2;

    // Command codes as they arrive on the cmd port.
    localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 3'd0;
    localparam logic [CMD_W-1:0] CMD_PUSH_BACK  = 3'd1;
    localparam logic [CMD_W-1:0] CMD_POP_FRONT  = 3'd2;
    localparam logic [CMD_W-1:0] CMD_POP_BACK   = 3'd3;
    localparam logic [CMD_W-1:0] CMD_DUMP       = 3'd4;

    // Status codes returned with every result word.
    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

    typedef enum logic [2:0] {
        OP_PUSH_FRONT,
        OP_PUSH_BACK,
        OP_POP_FRONT,
        OP_POP_BACK,
        OP_DUMP
    } op_t;

    typedef struct packed {
        op_t                      op;
        logic signed [DATA_W-1:0] value;
    } cmd_word_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_POP_OUT,
        BK_DUMP
    } bk_state_t;

endpackage

/* rtl/deq_front.sv */
// ----------------------------------------------------------------------------
// deq_front
// Accepts command words, decodes them into operations, drops unused codes
// and holds decoded words in a two-entry queue for the back part.
// ----------------------------------------------------------------------------
module deq_front
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic [deq_pkg::CMD_W-1:0]         cmd,
    input  logic signed [deq_pkg::DATA_W-1:0] value,
    output logic                              busy,
    output logic                              q_valid,
    output deq_pkg::cmd_word_t                q_word,
    input  logic                              q_pop
);
    import deq_pkg::*;

    cmd_word_t  slot_reg [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;

    logic       dec_valid;
    op_t        dec_op;
    logic       push;
    logic       pop;

    // Command decoder; unused codes produce no word.
    always_comb
    begin
        dec_valid = 1'b1;
        dec_op    = OP_DUMP;
        unique case (cmd)
            CMD_PUSH_FRONT: dec_op = OP_PUSH_FRONT;
            CMD_PUSH_BACK:  dec_op = OP_PUSH_BACK;
            CMD_POP_FRONT:  dec_op = OP_POP_FRONT;
            CMD_POP_BACK:   dec_op = OP_POP_BACK;
            CMD_DUMP:       dec_op = OP_DUMP;
            default:        dec_valid = 1'b0;
        endcase
    end

    assign busy    = (count_reg == 2'd2);
    assign q_valid = (count_reg != 2'd0);
    assign q_word  = slot_reg[rd_ptr_reg];

    assign push = start && !busy && dec_valid;
    assign pop  = q_pop && q_valid;

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= '{op: dec_op, value: value};
        end
    end

endmodule

/* rtl/deq_back.sv */
// ----------------------------------------------------------------------------
// deq_back
// Executes decoded operations against the circular store, keeps the front
// index and the occupancy, and drives the registered result port.
// ----------------------------------------------------------------------------
module deq_back
#(
    parameter int DEPTH = deq_pkg::DEPTH_DEFAULT
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                q_valid,
    input  deq_pkg::cmd_word_t                  q_word,
    output logic                                q_pop,
    output logic                                strobe,
    output logic signed [deq_pkg::DATA_W-1:0]   result_value,
    output logic [deq_pkg::STATUS_W-1:0]        status,
    output logic                                last
);
    import deq_pkg::*;

    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int SUM_W = CNT_W + 1;

    logic signed [DATA_W-1:0] mem [DEPTH];
    logic signed [DATA_W-1:0] rd_data_reg;

    bk_state_t            state_reg;
    bk_state_t            state_next;
    logic [IDX_W-1:0]     front_reg;
    logic [IDX_W-1:0]     front_next;
    logic [CNT_W-1:0]     occ_reg;
    logic [CNT_W-1:0]     occ_next;
    logic [CNT_W-1:0]     cnt_reg;
    logic [CNT_W-1:0]     cnt_next;

    logic                     strobe_reg;
    logic                     strobe_next;
    logic signed [DATA_W-1:0] value_reg;
    logic signed [DATA_W-1:0] value_next;
    logic [STATUS_W-1:0]      status_reg;
    logic [STATUS_W-1:0]      status_next;
    logic                     last_reg;
    logic                     last_next;

    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    logic [IDX_W-1:0] rd_addr;
    logic             is_full;
    logic             is_empty;
    logic             dump_last;
    logic [IDX_W-1:0] front_dec;

    // Position base + off modulo DEPTH, for base below DEPTH and off at most DEPTH.
    function automatic logic [IDX_W-1:0] wrap_add(input logic [IDX_W-1:0] base,
                                                  input logic [CNT_W-1:0] off);
        logic [SUM_W-1:0] sum;
        sum = SUM_W'(base) + SUM_W'(off);
        if (sum >= SUM_W'(DEPTH))
        begin
            sum = sum - SUM_W'(DEPTH);
        end
        return sum[IDX_W-1:0];
    endfunction

    assign is_full   = (occ_reg == CNT_W'(DEPTH));
    assign is_empty  = (occ_reg == '0);
    assign dump_last = (cnt_reg == occ_reg - CNT_W'(1));
    assign front_dec = (front_reg == '0) ? IDX_W'(DEPTH - 1) : front_reg - IDX_W'(1);

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            BK_IDLE:
            begin
                if (q_valid)
                begin
                    case (q_word.op)
                        OP_POP_FRONT, OP_POP_BACK:
                            if (!is_empty) state_next = BK_POP_OUT;
                        OP_DUMP:
                            if (!is_empty) state_next = BK_DUMP;
                        default:
                            state_next = BK_IDLE;
                    endcase
                end
            end
            BK_POP_OUT:
                state_next = BK_IDLE;
            BK_DUMP:
                if (dump_last) state_next = BK_IDLE;
            default:
                state_next = BK_IDLE;
        endcase
    end

    // Outputs and datapath updates.
    always_comb
    begin
        q_pop       = 1'b0;
        wr_en       = 1'b0;
        wr_addr     = front_reg;
        rd_addr     = front_reg;
        front_next  = front_reg;
        occ_next    = occ_reg;
        cnt_next    = cnt_reg;
        strobe_next = 1'b0;
        value_next  = '0;
        status_next = ST_OK;
        last_next   = 1'b1;
        unique case (state_reg)
            BK_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop = 1'b1;
                    strobe_next = 1'b1;
                    case (q_word.op)
                        OP_PUSH_FRONT, OP_PUSH_BACK:
                        begin
                            if (is_full)
                            begin
                                status_next = ST_FULL;
                            end
                            else
                            begin
                                wr_en    = 1'b1;
                                occ_next = occ_reg + CNT_W'(1);
                                if (q_word.op == OP_PUSH_FRONT)
                                begin
                                    wr_addr    = front_dec;
                                    front_next = front_dec;
                                end
                                else
                                begin
                                    wr_addr = wrap_add(front_reg, occ_reg);
                                end
                            end
                        end
                        OP_POP_FRONT, OP_POP_BACK:
                        begin
                            if (is_empty)
                            begin
                                status_next = ST_EMPTY;
                            end
                            else
                            begin
                                // The value leaves via rd_data_reg and POP_OUT.
                                strobe_next = 1'b0;
                                occ_next    = occ_reg - CNT_W'(1);
                                if (q_word.op == OP_POP_FRONT)
                                begin
                                    rd_addr    = front_reg;
                                    front_next = wrap_add(front_reg, CNT_W'(1));
                                end
                                else
                                begin
                                    rd_addr = wrap_add(front_reg, occ_reg - CNT_W'(1));
                                end
                            end
                        end
                        default:
                        begin
                            if (is_empty)
                            begin
                                status_next = ST_EMPTY;
                            end
                            else
                            begin
                                strobe_next = 1'b0;
                                rd_addr     = front_reg;
                                cnt_next    = '0;
                            end
                        end
                    endcase
                end
            end
            BK_POP_OUT:
            begin
                strobe_next = 1'b1;
                value_next  = rd_data_reg;
            end
            BK_DUMP:
            begin
                strobe_next = 1'b1;
                value_next  = rd_data_reg;
                last_next   = dump_last;
                rd_addr     = wrap_add(front_reg, cnt_reg + CNT_W'(1));
                cnt_next    = cnt_reg + CNT_W'(1);
            end
            default:
            begin
                strobe_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= BK_IDLE;
            front_reg  <= '0;
            occ_reg    <= '0;
            cnt_reg    <= '0;
            strobe_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            front_reg  <= front_next;
            occ_reg    <= occ_next;
            cnt_reg    <= cnt_next;
            strobe_reg <= strobe_next;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg  <= value_next;
        status_reg <= status_next;
        last_reg   <= last_next;
    end

    // Circular store: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= q_word.value;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign strobe       = strobe_reg;
    assign result_value = value_reg;
    assign status       = status_reg;
    assign last         = last_reg;

endmodule

/* rtl/double_ended_queue.sv */
// ----------------------------------------------------------------------------
// double_ended_queue
// Bounded double-ended queue of signed 32-bit words with push and pop at
// either end and a front-to-back dump.
// ----------------------------------------------------------------------------
// Usage:
// A command word (cmd, value) is taken at a rising edge where start is high
// and busy is low. Codes 0 and 1 push value at the front or back, 2 and 3
// pop from the front or back, 4 dumps the contents front to back. Other
// codes are taken and ignored. Each result word appears on result_value,
// status and last for exactly one cycle while strobe is high; the receiver
// has no way to stall it, so every result must be captured when it shows.
// The final result of a command carries last high; status reports ok,
// empty (pop or dump on an empty queue) or full (push dropped).
// A push or failed command reports via the result registers; a successful
// pop also passes the store read register and POP_OUT. The back end takes a
// push in idle, a pop in idle then POP_OUT, a dump in idle then BK_DUMP to
// the last word; one store read per cycle paces pops and dumps. A two-word
// command queue sits between decoder and back end; busy is high while full.
// Reset clears the indices and the command queue; the queue is empty after.
// ----------------------------------------------------------------------------
module double_ended_queue
#(
    parameter int DEPTH = deq_pkg::DEPTH_DEFAULT
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [deq_pkg::CMD_W-1:0]           cmd,
    input  logic signed [deq_pkg::DATA_W-1:0]   value,
    output logic                                strobe,
    output logic signed [deq_pkg::DATA_W-1:0]   result_value,
    output logic [deq_pkg::STATUS_W-1:0]        status,
    output logic                                last
);
    import deq_pkg::*;

    // Decoded command words handed from the front part to the back part.
    logic      q_valid;
    logic      q_pop;
    cmd_word_t q_word;

    deq_front u_front
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .cmd     (cmd),
        .value   (value),
        .busy    (busy),
        .q_valid (q_valid),
        .q_word  (q_word),
        .q_pop   (q_pop)
    );

    // The back part owns the store and the result registers.
    deq_back
    #(
        .DEPTH (DEPTH)
    )
    u_back
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_valid      (q_valid),
        .q_word       (q_word),
        .q_pop        (q_pop),
        .strobe       (strobe),
        .result_value (result_value),
        .status       (status),
        .last         (last)
    );

endmodule
